@@ rtl/core/olnq_pkg.sv @@
`timescale 1ns / 1ps

package olnq_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned ValW       = 32;

  // Request codes. The unused code is served as a query.
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CMP,
    S_NEXT,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    append_wr;
    logic    rd_cur;
    logic    rd_next;
    logic    scan_inc;
    logic    shift_wr;
    logic    count_dec;
    logic    take_next;
    logic    finish;
    logic    report;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_append;
    logic is_delete;
    logic full;
    logic at_end;
    logic match;
    logic has_next;
  } sts_t;

endpackage

@@ rtl/core/olnq_ctrl.sv @@
`timescale 1ns / 1ps

module olnq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  olnq_pkg::sts_t  sts_i,
  output olnq_pkg::cmd_t  cmd_o
);

  olnq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olnq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != olnq_pkg::S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = olnq_pkg::ST_OK;
    unique case (state_q)
      olnq_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = olnq_pkg::S_DECODE;
        end
      end
      olnq_pkg::S_DECODE: begin
        if (sts_i.is_append) begin
          cmd_o.finish = 1'b1;
          state_d      = olnq_pkg::S_IDLE;
          if (sts_i.full) begin
            cmd_o.status = olnq_pkg::ST_FULL;
          end else begin
            cmd_o.append_wr = 1'b1;
          end
        end else begin
          state_d = olnq_pkg::S_SCAN;
        end
      end
      olnq_pkg::S_SCAN: begin
        // Read the entry under the scan index, or give up at the tail.
        if (sts_i.at_end) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = olnq_pkg::ST_NOT_FOUND;
          state_d      = olnq_pkg::S_IDLE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = olnq_pkg::S_CMP;
        end
      end
      olnq_pkg::S_CMP: begin
        if (!sts_i.match) begin
          cmd_o.scan_inc = 1'b1;
          state_d        = olnq_pkg::S_SCAN;
        end else if (sts_i.is_delete) begin
          state_d = olnq_pkg::S_SHIFT_RD;
        end else if (sts_i.has_next) begin
          cmd_o.rd_next = 1'b1;
          state_d       = olnq_pkg::S_NEXT;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.report = 1'b1;
          state_d      = olnq_pkg::S_IDLE;
        end
      end
      olnq_pkg::S_NEXT: begin
        cmd_o.take_next = 1'b1;
        cmd_o.finish    = 1'b1;
        cmd_o.report    = 1'b1;
        state_d         = olnq_pkg::S_IDLE;
      end
      olnq_pkg::S_SHIFT_RD: begin
        // Pull the following entry down, or shrink the list when done.
        if (sts_i.has_next) begin
          cmd_o.rd_next = 1'b1;
          state_d       = olnq_pkg::S_SHIFT_WR;
        end else begin
          cmd_o.count_dec = 1'b1;
          cmd_o.finish    = 1'b1;
          state_d         = olnq_pkg::S_IDLE;
        end
      end
      olnq_pkg::S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = olnq_pkg::S_SHIFT_RD;
      end
      default: begin
        state_d = olnq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/olnq_datapath.sv @@
`timescale 1ns / 1ps

module olnq_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            req_type_i,
  input  logic [olnq_pkg::ValW-1:0] value_i,
  input  olnq_pkg::cmd_t        cmd_i,
  output olnq_pkg::sts_t        sts_o,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic                  prev_present_o,
  output logic [olnq_pkg::ValW-1:0] prev_value_o,
  output logic                  next_present_o,
  output logic [olnq_pkg::ValW-1:0] next_value_o
);

  logic [olnq_pkg::ValW-1:0] mem [olnq_pkg::MaxEntries];

  logic [olnq_pkg::CntW-1:0] count_q;
  logic [olnq_pkg::CntW-1:0] idx_q;
  logic [olnq_pkg::CntW-1:0] idx_plus1;
  logic [1:0]                req_q;
  logic [olnq_pkg::ValW-1:0] value_q;
  logic [olnq_pkg::ValW-1:0] rdata_q;
  logic [olnq_pkg::ValW-1:0] prev_q;
  logic [olnq_pkg::ValW-1:0] next_q;
  logic                      next_vld_q;

  logic                      wr_en;
  logic [olnq_pkg::IdxW-1:0] wr_addr;
  logic [olnq_pkg::ValW-1:0] wr_data;
  logic                      rd_en;
  logic [olnq_pkg::IdxW-1:0] rd_addr;

  logic                      done_q;
  logic [1:0]                status_q;
  logic                      prev_present_q;
  logic [olnq_pkg::ValW-1:0] prev_value_q;
  logic                      next_present_q;
  logic [olnq_pkg::ValW-1:0] next_value_q;

  assign idx_plus1 = idx_q + olnq_pkg::CntW'(1);

  // Status toward the controller.
  assign sts_o.is_append = (req_q == olnq_pkg::REQ_APPEND);
  assign sts_o.is_delete = (req_q == olnq_pkg::REQ_DELETE);
  assign sts_o.full      = (count_q == olnq_pkg::CntW'(olnq_pkg::MaxEntries));
  assign sts_o.at_end    = (idx_q >= count_q);
  assign sts_o.match     = (rdata_q == value_q);
  assign sts_o.has_next  = (idx_plus1 < count_q);

  // One write port: an append goes to the tail, a shift to the scan index.
  assign wr_en   = cmd_i.append_wr | cmd_i.shift_wr;
  assign wr_addr = cmd_i.append_wr ? count_q[olnq_pkg::IdxW-1:0] : idx_q[olnq_pkg::IdxW-1:0];
  assign wr_data = cmd_i.append_wr ? value_q : rdata_q;
  assign rd_en   = cmd_i.rd_cur | cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_next ? idx_plus1[olnq_pkg::IdxW-1:0]
                                 : idx_q[olnq_pkg::IdxW-1:0];

  // Entry store with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Request capture and neighbor tracking during the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      value_q <= value_i;
      prev_q  <= '0;
      next_q  <= '0;
    end else begin
      if (cmd_i.scan_inc) begin
        prev_q <= rdata_q;
      end
      if (cmd_i.take_next) begin
        next_q <= rdata_q;
      end
    end
  end

  // Fill count, scan index and next-present flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      next_vld_q <= 1'b0;
    end else begin
      if (cmd_i.append_wr) begin
        count_q <= count_q + olnq_pkg::CntW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - olnq_pkg::CntW'(1);
      end
      if (cmd_i.load) begin
        idx_q      <= '0;
        next_vld_q <= 1'b0;
      end else begin
        if (cmd_i.scan_inc || cmd_i.shift_wr) begin
          idx_q <= idx_plus1;
        end
        if (cmd_i.take_next) begin
          next_vld_q <= 1'b1;
        end
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // Result payload; neighbors are reported only for a query that hit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q       <= cmd_i.status;
      prev_present_q <= cmd_i.report & (idx_q != '0);
      prev_value_q   <= cmd_i.report ? prev_q : '0;
      next_present_q <= cmd_i.report & (next_vld_q | cmd_i.take_next);
      if (cmd_i.take_next) begin
        next_value_q <= rdata_q;
      end else begin
        next_value_q <= cmd_i.report ? next_q : '0;
      end
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign prev_present_o = prev_present_q;
  assign prev_value_o   = prev_value_q;
  assign next_present_o = next_present_q;
  assign next_value_o   = next_value_q;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olnq_pkg::CntW'(olnq_pkg::MaxEntries))
    else $error("fill count above capacity");

  // An append is never written into a full list.
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append_wr |-> !sts_o.full)
    else $error("append written into a full list");

  // A full status is only reported when the list really is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && cmd_i.status == olnq_pkg::ST_FULL) |-> sts_o.full)
    else $error("full status on a list with room");

  // Each request yields one strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

endmodule

@@ rtl/core/ordered_list_with_neighbour_query.sv @@
`timescale 1ns / 1ps

// Bounded list of signed 32-bit values kept in insertion order.
// Request channel: drive req_type_i and value_i and raise start; the
// request is transferred at a rising edge where start is high and busy is
// low. Request 0 appends at the tail, 1 deletes the first equal entry and
// closes the gap, 2 (or 3) looks up the first equal entry and returns its
// predecessor and successor.
// Result channel: done_o is high for exactly one cycle per request, with
// status_o and the neighbor fields valid in that cycle. The receiver cannot
// stall, so the result is transferred at the edge that ends that cycle.
// Sequencing: an append keeps busy high through the decode state after its
// transfer, and the strobe follows in the next cycle. Lookups and deletes
// scan the store through its single read port, visiting each entry with an
// address step, then a compare on registered read data; a delete then
// shifts each later entry down with a read, then a write. Either way the
// strobe shows in the cycle after the last busy cycle. busy is low while
// the strobe is shown, so a new request may be transferred at the edge
// that ends the strobe cycle.
// Reset empties the list at once; stored values are not cleared.
module ordered_list_with_neighbour_query (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               prev_present_o,
  output logic signed [31:0] prev_value_o,
  output logic               next_present_o,
  output logic signed [31:0] next_value_o
);

  olnq_pkg::cmd_t cmd;
  olnq_pkg::sts_t sts;

  // Sequencer for the scan, shift and result steps.
  olnq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Entry store, fill count and result registers.
  olnq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .status_o       (status_o),
    .prev_present_o (prev_present_o),
    .prev_value_o   (prev_value_o),
    .next_present_o (next_present_o),
    .next_value_o   (next_value_o)
  );

endmodule
